// File: src/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the soft timer pool
// Request and response payloads, operation codes, the per-pass result
// accumulator and the default sizing of the pool.
// ----------------------------------------------------------------------------
package stp_pkg;

  // Default sizing
  localparam int NUM_TIMERS_DEF = 64;
  localparam int TIME_WIDTH_DEF = 32;

  // Operation codes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_ALLOC   = 3'd1;
  localparam logic [2:0] MODE_RELEASE = 3'd2;
  localparam logic [2:0] MODE_CHECK   = 3'd3;
  localparam logic [2:0] MODE_RESTART = 3'd4;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Request payload
  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  slot;
    logic [31:0] duration;
    logic        start_flag;
  } req_t;

  // Response payload
  typedef struct packed {
    logic       status;
    logic [5:0] granted_slot;
    logic       fired;
  } rsp_t;

  // Result gathered while the ring turns past the head unit
  typedef struct packed {
    logic       found;
    logic       status;
    logic [5:0] granted_slot;
    logic       fired;
  } acc_t;

endpackage
`default_nettype wire

// File: src/soft_timer_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soft_timer_pool: bank of one-shot timers on a shared time counter
// Timer records sit in a ring of cells that turns once per request past a
// single operation unit.
// ----------------------------------------------------------------------------
// Each request is taken in the idle state and then makes one full turn of the
// ring of NUM_TIMERS cells, one record per cycle through the head unit, which
// does the elapsed-time compare for a tick, the first-free search for an
// allocate and the slot match for the others. The response is registered; a
// new request is taken while it waits, and the ring only pauses on its final
// step if the previous response is still untaken. Reset clears all timers at
// once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module soft_timer_pool #(
  parameter int NUM_TIMERS = stp_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = stp_pkg::TIME_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire stp_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output stp_pkg::rsp_t      rsp
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CMP_W = (IDX_W > 6) ? IDX_W : 6;
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                state;
  logic [IDX_W-1:0]      pos;
  logic [TIME_WIDTH-1:0] now_count;
  logic [2:0]            op_mode;
  logic [5:0]            op_slot;
  logic [TIME_WIDTH-1:0] op_dur;
  logic                  op_flag;
  stp_pkg::acc_t         acc;
  stp_pkg::acc_t         acc_next;

  logic                     last;
  logic                     ring_en;
  logic                     hit;
  logic [CMP_W-1:0]         pos_ext;
  logic [TIME_WIDTH+31:0]   dur_ext;

  // Ring wiring: cell i feeds from cell i+1, the tail from the head unit
  logic [TIME_WIDTH-1:0] cell_start [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] cell_limit [NUM_TIMERS];
  logic                  cell_flag  [NUM_TIMERS];
  logic [TIME_WIDTH-1:0] head_start;
  logic [TIME_WIDTH-1:0] head_limit;
  logic                  head_flag;

  assign req_ready = (state == S_IDLE);
  assign last      = (pos == LAST_POS);
  assign ring_en   = (state == S_RUN) && !(last && rsp_valid && !rsp_ready);
  assign pos_ext   = CMP_W'(pos);
  assign hit       = (CMP_W'(op_slot) == pos_ext);
  assign dur_ext   = {{TIME_WIDTH{1'b0}}, req.duration};

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    if (i == NUM_TIMERS - 1) begin : g_tail
      stp_cell #(
        .TIME_WIDTH(TIME_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (ring_en),
        .start_in (head_start),
        .limit_in (head_limit),
        .flag_in  (head_flag),
        .start_out(cell_start[i]),
        .limit_out(cell_limit[i]),
        .flag_out (cell_flag[i])
      );
    end else begin : g_body
      stp_cell #(
        .TIME_WIDTH(TIME_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (ring_en),
        .start_in (cell_start[i+1]),
        .limit_in (cell_limit[i+1]),
        .flag_in  (cell_flag[i+1]),
        .start_out(cell_start[i]),
        .limit_out(cell_limit[i]),
        .flag_out (cell_flag[i])
      );
    end
  end

  // Operation unit on the record leaving cell 0
  stp_head #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_head (
    .mode      (op_mode),
    .hit       (hit),
    .pos_low   (pos_ext[5:0]),
    .dur       (op_dur),
    .start_flag(op_flag),
    .now_count (now_count),
    .acc_in    (acc),
    .start_in  (cell_start[0]),
    .limit_in  (cell_limit[0]),
    .flag_in   (cell_flag[0]),
    .acc_out   (acc_next),
    .start_out (head_start),
    .limit_out (head_limit),
    .flag_out  (head_flag)
  );

  // Sequence one request per ring turn and hold the response
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      now_count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // drop the response once transferred, unless a new one lands now
      if (rsp_valid && rsp_ready && !(ring_en && last)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_mode          <= req.mode;
            op_slot          <= req.slot;
            op_dur           <= dur_ext[TIME_WIDTH-1:0];
            op_flag          <= req.start_flag;
            acc.found        <= 1'b0;
            acc.status       <= (req.mode == stp_pkg::MODE_TICK) ?
                                stp_pkg::STATUS_OK : stp_pkg::STATUS_FAIL;
            acc.granted_slot <= '0;
            acc.fired        <= 1'b0;
            pos              <= '0;
            state            <= S_RUN;
            // advance time before the flags are scanned
            if (req.mode == stp_pkg::MODE_TICK) begin
              now_count <= now_count + 1'b1;
            end
          end
        end
        S_RUN: begin
          if (ring_en) begin
            acc <= acc_next;
            if (last) begin
              rsp.status       <= acc_next.status;
              rsp.granted_slot <= acc_next.granted_slot;
              rsp.fired        <= acc_next.fired;
              rsp_valid        <= 1'b1;
              pos              <= '0;
              state            <= S_IDLE;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A tick transfer advances time by one
  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.mode == stp_pkg::MODE_TICK) |=>
      (now_count == TIME_WIDTH'($past(now_count) + 1'b1)))
    else $error("time counter did not advance on tick");

  // Other requests leave time alone
  a_time_steady: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.mode != stp_pkg::MODE_TICK) |=> $stable(now_count))
    else $error("time counter moved on a non-tick request");

  // A response appears only at the end of a ring turn
  a_rsp_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_RUN))
    else $error("response raised outside a ring turn");

  // The ring rests at its home position between requests
  a_home_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (pos == '0))
    else $error("ring position not home while idle");

  // No second request is taken while a turn is under way
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken during a ring turn");

endmodule
`default_nettype wire

// File: src/stp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stp_cell: one timer record in the rotating ring
// Holds start time, timeout and signalled flag of one slot and hands the
// record to its neighbor whenever the ring advances.
// ----------------------------------------------------------------------------
module stp_cell #(
  parameter int TIME_WIDTH = stp_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  shift,
  input  wire logic [TIME_WIDTH-1:0] start_in,
  input  wire logic [TIME_WIDTH-1:0] limit_in,
  input  wire logic                  flag_in,
  output logic      [TIME_WIDTH-1:0] start_out,
  output logic      [TIME_WIDTH-1:0] limit_out,
  output logic                       flag_out
);

  // Start time is only read for active slots, so it needs no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      start_out <= start_in;
    end
  end

  // Timeout and flag reset to a free, unsignalled slot
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_out <= '0;
      flag_out  <= 1'b0;
    end else if (shift) begin
      limit_out <= limit_in;
      flag_out  <= flag_in;
    end
  end

endmodule
`default_nettype wire

// File: src/stp_head.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stp_head: operation unit at the head of the ring
// Applies the current operation to the record leaving the first cell and
// updates the running result before the record re-enters at the tail.
// ----------------------------------------------------------------------------
module stp_head #(
  parameter int TIME_WIDTH = stp_pkg::TIME_WIDTH_DEF
) (
  input  wire logic [2:0]            mode,
  input  wire logic                  hit,
  input  wire logic [5:0]            pos_low,
  input  wire logic [TIME_WIDTH-1:0] dur,
  input  wire logic                  start_flag,
  input  wire logic [TIME_WIDTH-1:0] now_count,
  input  wire stp_pkg::acc_t         acc_in,
  input  wire logic [TIME_WIDTH-1:0] start_in,
  input  wire logic [TIME_WIDTH-1:0] limit_in,
  input  wire logic                  flag_in,
  output stp_pkg::acc_t              acc_out,
  output logic      [TIME_WIDTH-1:0] start_out,
  output logic      [TIME_WIDTH-1:0] limit_out,
  output logic                       flag_out
);

  logic                  active;
  logic [TIME_WIDTH-1:0] elapsed;

  assign active  = (limit_in != '0);
  assign elapsed = now_count - start_in;

  // Update the passing record and the running result
  always_comb begin
    acc_out   = acc_in;
    start_out = start_in;
    limit_out = limit_in;
    flag_out  = flag_in;
    case (mode)
      stp_pkg::MODE_TICK: begin
        if (active && !flag_in) begin
          flag_out = (elapsed >= limit_in);
        end
      end
      stp_pkg::MODE_ALLOC: begin
        // claim the first free slot seen in this pass, if the duration is nonzero
        if (!acc_in.found && (dur != '0) && !active) begin
          start_out            = now_count;
          limit_out            = dur;
          flag_out             = start_flag;
          acc_out.found        = 1'b1;
          acc_out.status       = stp_pkg::STATUS_OK;
          acc_out.granted_slot = pos_low;
        end
      end
      stp_pkg::MODE_RELEASE: begin
        if (hit && active) begin
          limit_out      = '0;
          acc_out.status = stp_pkg::STATUS_OK;
        end
      end
      stp_pkg::MODE_CHECK: begin
        if (hit && active) begin
          acc_out.fired  = flag_in;
          acc_out.status = stp_pkg::STATUS_OK;
        end
      end
      stp_pkg::MODE_RESTART: begin
        if (hit && active) begin
          start_out      = now_count;
          flag_out       = 1'b0;
          acc_out.status = stp_pkg::STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: verif/tb_soft_timer_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_soft_timer_pool: self-checking bench for the soft timer pool
// Drives timer requests over the valid/ready request channel, predicts every
// response from a behavioral copy of the timer bank and compares each
// response transfer field by field, mostly under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_soft_timer_pool;
  import stp_pkg::*;

  localparam int NUM_SLOTS = NUM_TIMERS_DEF;

  // Behavioral timer bank plus the queue of responses it owes
  class timer_pool_scoreboard;
    logic [31:0] now_count;
    logic [31:0] start_time [NUM_SLOTS];
    logic [31:0] limit [NUM_SLOTS];
    bit          flag [NUM_SLOTS];
    rsp_t        due_rsp_q [$];
    int unsigned mismatches;

    function new();
      now_count  = '0;
      mismatches = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        start_time[i] = '0;
        limit[i]      = '0;
        flag[i]       = 1'b0;
      end
    endfunction

    function bit is_active(logic [5:0] slot);
      return (int'(slot) < NUM_SLOTS) && (limit[slot] != 0);
    endfunction

    // Apply one request to the bank and return the response it earns
    function rsp_t apply_request(req_t r);
      rsp_t        rsp;
      logic [31:0] elapsed;
      bit          placed;
      rsp    = '{status: STATUS_FAIL, granted_slot: 6'd0, fired: 1'b0};
      placed = 1'b0;
      case (r.mode)
        MODE_TICK: begin
          now_count = now_count + 32'd1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (limit[i] != 0 && !flag[i]) begin
              elapsed = now_count - start_time[i];
              flag[i] = (elapsed >= limit[i]);
            end
          end
          rsp.status = STATUS_OK;
        end
        MODE_ALLOC: begin
          if (r.duration != 0) begin
            for (int i = 0; i < NUM_SLOTS && !placed; i++) begin
              if (limit[i] == 0) begin
                start_time[i]    = now_count;
                limit[i]         = r.duration;
                flag[i]          = r.start_flag;
                rsp.status       = STATUS_OK;
                rsp.granted_slot = 6'(i);
                placed           = 1'b1;
              end
            end
          end
        end
        MODE_RELEASE: begin
          if (is_active(r.slot)) begin
            limit[r.slot] = '0;
            rsp.status    = STATUS_OK;
          end
        end
        MODE_CHECK: begin
          if (is_active(r.slot)) begin
            rsp.fired  = flag[r.slot];
            rsp.status = STATUS_OK;
          end
        end
        MODE_RESTART: begin
          if (is_active(r.slot)) begin
            start_time[r.slot] = now_count;
            flag[r.slot]       = 1'b0;
            rsp.status         = STATUS_OK;
          end
        end
        default: begin
        end
      endcase
      return rsp;
    endfunction

    function void note_request(req_t r);
      due_rsp_q.push_back(apply_request(r));
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (due_rsp_q.size() == 0) begin
        mismatches++;
        $display("%0t: response with none expected, expected none, actual %p", $time, got);
        return;
      end
      want = due_rsp_q.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.granted_slot !== want.granted_slot)
        report("granted_slot", want.granted_slot, got.granted_slot);
      if (got.fired !== want.fired) report("fired", want.fired, got.fired);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  timer_pool_scoreboard sb = new();
  int unsigned          sent = 0;
  int unsigned          req_idle_pct = 16;
  int unsigned          rsp_idle_pct = 81;

  soft_timer_pool dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the response channel at random
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  // Check every response transfer
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  function automatic req_t make_req(logic [2:0] mode, logic [5:0] slot,
                                    logic [31:0] duration, logic start_flag);
    req_t r;
    r.mode       = mode;
    r.slot       = slot;
    r.duration   = duration;
    r.start_flag = start_flag;
    return r;
  endfunction

  // Mostly short timeouts so timers fire, with zero, full-range and all-ones mixed in
  function automatic logic [31:0] random_duration();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 8) return 32'd0;
    if (p < 16) return $urandom;
    if (p < 20) return 32'hFFFF_FFFF;
    return 32'($urandom_range(16, 1));
  endfunction

  // Random traffic, undefined modes included: slots mostly chosen among the live timers
  function automatic req_t random_request();
    req_t        r;
    int          live [$];
    int unsigned pick;
    int unsigned release_top;
    r.slot       = 6'($urandom_range(63));
    r.duration   = random_duration();
    r.start_flag = 1'($urandom_range(1));
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sb.limit[i] != 0) live.push_back(i);
    end
    if (live.size() != 0 && $urandom_range(9) < 8)
      r.slot = 6'(live[$urandom_range(live.size() - 1)]);
    release_top = (live.size() > 40) ? 99 : 88;
    pick = $urandom_range(99);
    if (pick < 32) r.mode = MODE_TICK;
    else if (pick < 52) r.mode = MODE_ALLOC;
    else if (pick < 72) r.mode = MODE_CHECK;
    else if (pick < 80) r.mode = MODE_RESTART;
    else if (pick < 83) r.mode = 3'($urandom_range(7, 5));
    else if (pick <= release_top) r.mode = MODE_RELEASE;
    else r.mode = MODE_CHECK;
    return r;
  endfunction

  // Drive one request and hold it until the transfer
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    sent++;
  endtask

  // Hold off the sender until every owed response has arrived
  task automatic wait_for_responses();
    req_valid <= 1'b0;
    while (sb.due_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Random traffic with occasional bursts of allocations that try to fill the whole bank
  task automatic random_items(input int unsigned upto);
    bit fill_now;
    fill_now = 1'b1;
    while (sent < upto) begin
      if (fill_now || $urandom_range(149) == 0) begin
        repeat (NUM_SLOTS + 2)
          send_request(make_req(MODE_ALLOC, 6'($urandom_range(63)), random_duration(),
                                1'($urandom_range(1))));
        fill_now = 1'b0;
      end else begin
        send_request(random_request());
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: free slots, zero timeout, extremes, firing, restart, undefined modes
    send_request(make_req(MODE_TICK, 6'd0, 32'd0, 1'b0));
    send_request(make_req(MODE_CHECK, 6'd0, 32'd0, 1'b0));
    send_request(make_req(MODE_RELEASE, 6'd63, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(MODE_RESTART, 6'd5, 32'd0, 1'b0));
    send_request(make_req(MODE_ALLOC, 6'd0, 32'd0, 1'b1));
    send_request(make_req(MODE_ALLOC, 6'd0, 32'd1, 1'b0));
    send_request(make_req(MODE_ALLOC, 6'd63, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(MODE_ALLOC, 6'd0, 32'd2, 1'b0));
    send_request(make_req(MODE_CHECK, 6'd0, 32'd0, 1'b0));
    send_request(make_req(MODE_CHECK, 6'd1, 32'd0, 1'b0));
    send_request(make_req(MODE_TICK, 6'd0, 32'd0, 1'b0));
    send_request(make_req(MODE_CHECK, 6'd0, 32'd0, 1'b0));
    send_request(make_req(MODE_CHECK, 6'd2, 32'd0, 1'b0));
    send_request(make_req(MODE_TICK, 6'd0, 32'd0, 1'b0));
    send_request(make_req(MODE_CHECK, 6'd2, 32'd0, 1'b0));
    send_request(make_req(MODE_RESTART, 6'd0, 32'd0, 1'b0));
    send_request(make_req(MODE_CHECK, 6'd0, 32'd0, 1'b0));
    send_request(make_req(MODE_RELEASE, 6'd1, 32'd0, 1'b0));
    send_request(make_req(MODE_CHECK, 6'd1, 32'd0, 1'b0));
    send_request(make_req(MODE_ALLOC, 6'd0, 32'h8000_0000, 1'b0));
    send_request(make_req(3'd5, 6'd63, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(3'd6, 6'd0, 32'd1, 1'b0));
    send_request(make_req(3'd7, 6'd2, 32'd2, 1'b1));
    send_request(make_req(MODE_RELEASE, 6'd0, 32'd0, 1'b0));

    random_items(517);
    wait_for_responses();

    req_idle_pct = 81;
    rsp_idle_pct = 16;
    random_items(1034);
    wait_for_responses();

    req_idle_pct = 0;
    rsp_idle_pct = 0;
    random_items(1550);
    wait_for_responses();

    repeat (2 * (NUM_SLOTS + 1)) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_rsp_q.size() == 0) begin
      $display("soft_timer_pool verification clean");
    end else begin
      $display("soft_timer_pool verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("soft_timer_pool verification failed");
    $finish;
  end

endmodule
